/* src/wrw_pkg.sv */
`timescale 1ns / 1ps
package wrw_pkg;

    // Node ids on the ports are always 4 bits wide.
    localparam int NODE_W = 4;
    // Bits of the visited mask, one per encodable node id.
    localparam int VIS_W = 2 ** NODE_W;
    localparam int NR_COMP = 4;
    localparam int ADDR_W = 16;

    localparam int DEF_NODES = 16;
    localparam int DEF_RULES_PER_NODE = 16;
    localparam int DEF_TOKEN_BITS = 16;

    // Stream payload layout.
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        ST_DELIVERED = 2'd0,
        ST_LOOP      = 2'd1,
        ST_STUCK     = 2'd2
    } t_status;

    typedef enum logic {
        FN_LOAD  = 1'b0,
        FN_ROUTE = 1'b1
    } t_func;

    // Rule valid bit and forwarding node.
    typedef struct packed {
        logic              valid;
        logic [NODE_W-1:0] next_node;
    } t_rule_tgt;

endpackage

/* src/wrw_rule_table.sv */
`timescale 1ns / 1ps
module wrw_rule_table #(
    parameter int NODES          = 16,
    parameter int RULES_PER_NODE = 16,
    parameter int TOKEN_BITS     = 16,
    localparam int TOTAL = NODES * RULES_PER_NODE,
    localparam int IDX_W = $clog2(TOTAL),
    localparam int PAT_W = 4 * TOKEN_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [IDX_W-1:0]   i_wr_idx,
    input  logic [PAT_W-1:0]   i_wr_pat,
    input  wrw_pkg::t_rule_tgt i_wr_tgt,
    input  logic               i_rd_en,
    input  logic [IDX_W-1:0]   i_rd_idx,
    output logic [PAT_W-1:0]   o_rd_pat,
    output wrw_pkg::t_rule_tgt o_rd_tgt
);
    import wrw_pkg::*;

    // Patterns and next node share one memory; valid bits live in flops so reset clears them.
    logic [PAT_W+NODE_W-1:0] r_mem [TOTAL];
    logic [PAT_W+NODE_W-1:0] r_rd_q;
    logic [TOTAL-1:0]        r_vld;
    logic                    r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= {i_wr_tgt.next_node, i_wr_pat};
        end
        if (i_rd_en) begin
            r_rd_q   <= r_mem[i_rd_idx];
            r_rd_vld <= r_vld[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_idx] <= i_wr_tgt.valid;
        end
    end

    always_comb begin
        o_rd_pat           = r_rd_q[PAT_W-1:0];
        o_rd_tgt.valid     = r_rd_vld;
        o_rd_tgt.next_node = r_rd_q[PAT_W +: NODE_W];
    end

endmodule

/* src/wildcard_route_walker.sv */
`timescale 1ns / 1ps
// First-match wildcard routing table with a hop walker. A load request (tuser 0) writes one
// rule and returns nothing. A route request (tuser 1) walks from its start node and returns
// one result: delivered, loop or unable to route. Each hop scans the node's rule slots in
// order through the single read port of the rule memory, one slot a cycle, with one shared
// rule comparator, and stops at the first match or after the last slot. The input is not
// ready while a route walks. A result waits in the output register while new requests are
// taken; a route that finishes before it drains holds there. Rules are invalid after reset;
// no clearing pass is needed.
module wildcard_route_walker #(
    parameter int NODES          = wrw_pkg::DEF_NODES,
    parameter int RULES_PER_NODE = wrw_pkg::DEF_RULES_PER_NODE,
    parameter int TOKEN_BITS     = wrw_pkg::DEF_TOKEN_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // node[3:0], slot[7:4], next_node[11:8], rule_valid[12], addr_a[28:13],
    // addr_b[44:29], addr_c[60:45], addr_d[76:61], zero fill [79:77]
    input  logic [wrw_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // func[0]
    input  logic                          s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status[1:0], where_node[5:2], zero fill [7:6]
    output logic [wrw_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import wrw_pkg::*;

    localparam int TOTAL  = NODES * RULES_PER_NODE;
    localparam int IDX_W  = $clog2(TOTAL);
    localparam int PAT_W  = NR_COMP * TOKEN_BITS;
    localparam int SCNT_W = $clog2(RULES_PER_NODE + 1);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;

    logic [NODE_W-1:0]     r_cur;
    logic [VIS_W-1:0]      r_visited;
    logic [SCNT_W-1:0]     r_issue;
    logic                  r_pend;
    logic                  r_last;
    logic [PAT_W-1:0]      r_addr;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic [NODE_W-1:0]     r_out_where;

    // input unpacking
    logic                  in_acc;
    logic [NODE_W-1:0]     in_node;
    logic [NODE_W-1:0]     in_slot;
    logic [NODE_W-1:0]     in_next;
    logic                  in_rvalid;
    logic [PAT_W-1:0]      in_pat;

    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    t_rule_tgt             wr_tgt;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_idx;
    logic [PAT_W-1:0]      rd_pat;
    t_rule_tgt             rd_tgt;

    logic                  node_ok;
    logic                  cmp_eq;
    logic                  hit;
    logic                  dec;
    t_status               dec_status;
    logic [NODE_W-1:0]     dec_where;
    logic                  out_free;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign in_node   = s_axis_tdata[3:0];
    assign in_slot   = s_axis_tdata[7:4];
    assign in_next   = s_axis_tdata[11:8];
    assign in_rvalid = s_axis_tdata[12];

    always_comb begin
        for (int k = 0; k < NR_COMP; k++) begin
            in_pat[k*TOKEN_BITS +: TOKEN_BITS] = s_axis_tdata[13 + k*ADDR_W +: TOKEN_BITS];
        end
    end

    assign wr_en = in_acc && (t_func'(s_axis_tuser) == FN_LOAD)
                   && (int'(in_node) < NODES) && (int'(in_slot) < RULES_PER_NODE);
    assign wr_idx = IDX_W'(int'(in_node) * RULES_PER_NODE + int'(in_slot));
    assign wr_tgt = '{valid: in_rvalid, next_node: in_next};

    wrw_rule_table #(
        .NODES          (NODES),
        .RULES_PER_NODE (RULES_PER_NODE),
        .TOKEN_BITS     (TOKEN_BITS)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (wr_en),
        .i_wr_idx (wr_idx),
        .i_wr_pat (in_pat),
        .i_wr_tgt (wr_tgt),
        .i_rd_en  (rd_en),
        .i_rd_idx (rd_idx),
        .o_rd_pat (rd_pat),
        .o_rd_tgt (rd_tgt)
    );

    // shared comparator: every non-wildcard pattern must equal its token
    always_comb begin
        cmp_eq = 1'b1;
        for (int k = 0; k < NR_COMP; k++) begin
            if ((rd_pat[k*TOKEN_BITS +: TOKEN_BITS] != '0)
                && (rd_pat[k*TOKEN_BITS +: TOKEN_BITS] != r_addr[k*TOKEN_BITS +: TOKEN_BITS]))
            begin
                cmp_eq = 1'b0;
            end
        end
    end

    assign node_ok  = int'(r_cur) < NODES;
    assign hit      = r_pend && rd_tgt.valid && cmp_eq;
    assign out_free = !r_out_valid || m_axis_tready;

    always_comb begin
        dec        = 1'b0;
        dec_status = ST_STUCK;
        dec_where  = r_cur;
        if (r_state == S_SCAN) begin
            if (!node_ok) begin
                dec = 1'b1;
            end else if (hit) begin
                if (rd_tgt.next_node == r_cur) begin
                    dec        = 1'b1;
                    dec_status = ST_DELIVERED;
                end else if (r_visited[rd_tgt.next_node]) begin
                    dec        = 1'b1;
                    dec_status = ST_LOOP;
                    dec_where  = rd_tgt.next_node;
                end
            end else if (r_pend && r_last) begin
                dec = 1'b1;
            end
        end
    end

    assign rd_en  = (r_state == S_SCAN) && node_ok && (int'(r_issue) < RULES_PER_NODE) && !hit;
    assign rd_idx = IDX_W'(int'(r_cur) * RULES_PER_NODE + int'(r_issue));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_visited    <= '0;
            r_issue      <= '0;
            r_pend       <= 1'b0;
            r_last       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_status <= ST_DELIVERED;
            r_out_where  <= '0;
        end else begin
            // a result loaded this cycle takes precedence over the drain
            if (m_axis_tready && !((r_state == S_SCAN) && dec)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && (t_func'(s_axis_tuser) == FN_ROUTE)) begin
                        r_state   <= S_SCAN;
                        r_cur     <= in_node;
                        r_visited <= VIS_W'(1) << in_node;
                        r_issue   <= '0;
                        r_pend    <= 1'b0;
                        r_addr    <= in_pat;
                    end
                end
                S_SCAN: begin
                    if (dec) begin
                        if (out_free) begin
                            r_out_valid  <= 1'b1;
                            r_out_status <= dec_status;
                            r_out_where  <= dec_where;
                            r_pend       <= 1'b0;
                            r_state      <= S_IDLE;
                        end
                    end else if (hit) begin
                        // forward one hop and restart the slot scan there
                        r_cur                       <= rd_tgt.next_node;
                        r_visited[rd_tgt.next_node] <= 1'b1;
                        r_issue                     <= '0;
                        r_pend                      <= 1'b0;
                    end else begin
                        r_pend  <= rd_en;
                        r_last  <= int'(r_issue) == RULES_PER_NODE - 1;
                        r_issue <= r_issue + SCNT_W'(rd_en);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_where, r_out_status};

    a_cur_visited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> r_visited[r_cur])
        else $error("current node not marked visited");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend)
        else $error("pending read left over after route end");

    a_hop_new_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && $past(r_state == S_SCAN) && (r_cur != $past(r_cur)))
        |-> ($countones(r_visited) == $countones($past(r_visited)) + 1))
        else $error("hop moved to an already visited node");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((r_out_status == ST_DELIVERED) || (r_out_status == ST_LOOP)
                           || (r_out_status == ST_STUCK)))
        else $error("bad status code on result");

endmodule
